// ----- rtl/core/kscg_pkg.sv -----
// kscg_pkg: shared widths and key tables for the sky gradient core
// keyframe times in half-hours and key colors in q0.16
// no dependencies
package kscg_pkg;

	localparam int TIME_W      = 16;
	localparam int POS_W       = 16;
	localparam int OUT_W       = 12;
	localparam int KEY_TBL     = 16;
	localparam int SEG_W       = 4;
	localparam int HH_W        = 6;
	localparam int KCOLOR_W    = 16;
	localparam int POS_CLAMP_W = 13;
	localparam int POS_ONE     = 4096;
	localparam int POS_SHIFT   = 12;

	// slot offsets inside a key color row
	localparam int CH_ZEN   = 0;
	localparam int CH_HOR   = 3;
	localparam int CH_COUNT = 3;
	localparam int ROW_LEN  = 6;

	typedef logic [HH_W-1:0]     hh_t;
	typedef logic [KCOLOR_W-1:0] kcolor_t;
	typedef logic [SEG_W-1:0]    seg_t;

	localparam hh_t KEY_HH [KEY_TBL] = '{
		6'd0, 6'd10, 6'd13, 6'd18, 6'd24, 6'd34, 6'd37, 6'd40, 6'd48,
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0
	};

	localparam kcolor_t KEY_COLOR [KEY_TBL][ROW_LEN] = '{
		'{16'd1311,  16'd1311,  16'd3932,  16'd2621,  16'd2621,  16'd6554},
		'{16'd3932,  16'd4588,  16'd10486, 16'd13107, 16'd9175,  16'd11796},
		'{16'd19661, 16'd26214, 16'd40632, 16'd62259, 16'd36045, 16'd22938},
		'{16'd24904, 16'd38011, 16'd58982, 16'd45875, 16'd53740, 16'd62259},
		'{16'd19661, 16'd36045, 16'd62259, 16'd40632, 16'd52429, 16'd64225},
		'{16'd22282, 16'd34079, 16'd56361, 16'd52429, 16'd51118, 16'd57672},
		'{16'd15729, 16'd18350, 16'd36045, 16'd64225, 16'd31457, 16'd18350},
		'{16'd5243,  16'd5898,  16'd14418, 16'd19661, 16'd10486, 16'd14418},
		'{16'd1311,  16'd1311,  16'd3932,  16'd2621,  16'd2621,  16'd6554},
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
	};

endpackage

// ----- rtl/core/kscg_front.sv -----
// kscg_front: accepts requests, wraps the time to one day, finds the key segment
// and clamps the height; two pipeline stages
// depends on kscg_pkg
module kscg_front #(
	parameter int KEY_COUNT      = 9,
	parameter int COLOR_BITS     = 12,
	parameter int HOUR_FRAC_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [kscg_pkg::TIME_W-1:0]          time_of_day,
	input  logic signed [kscg_pkg::POS_W-1:0]    height_pos,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output kscg_pkg::seg_t                       seg,
	output logic [HOUR_FRAC_BITS+4:0]            hour_off,
	output logic [COLOR_BITS:0]                  pos
);
	import kscg_pkg::*;

	localparam int LB  = HOUR_FRAC_BITS + 3;
	localparam int QB  = TIME_W - LB;
	localparam int ND  = (QB + 1) / 2;
	localparam int HW  = HOUR_FRAC_BITS + 5;
	localparam int FW  = COLOR_BITS + 1;
	localparam int PXW = POS_CLAMP_W + COLOR_BITS + 1;

	logic                   en;
	logic                   vld_s1, vld_s2;
	logic [2*ND-1:0]        hi_pad;
	logic [4:0]             dsum;
	logic [3:0]             fold1;
	logic [2:0]             fold2;
	logic [1:0]             rem3;
	logic [HW-1:0]          h_c;
	logic [POS_CLAMP_W-1:0] pcl_c;
	logic [HW-1:0]          h_s1;
	logic [POS_CLAMP_W-1:0] pcl_s1;
	seg_t                   seg_c;
	logic [HW-1:0]          lo_c;
	logic [PXW-1:0]         px_c;
	seg_t                   seg_s2;
	logic [HW-1:0]          dist_s2;
	logic [FW-1:0]          pos_s2;

	assign en       = !vld_s2 || out_ready;
	assign in_ready = en;

	// one day is 3 * 2^LB units: keep the low bits, take the high part mod 3
	// by summing base-4 digits (4 is 1 mod 3)
	always_comb begin
		hi_pad = (2*ND)'(time_of_day[TIME_W-1:LB]);
		dsum   = '0;
		for (int i = 0; i < ND; i++) begin
			dsum = dsum + 5'(hi_pad[2*i +: 2]);
		end
		fold1 = 4'(dsum[4:2]) + 4'(dsum[1:0]);
		fold2 = 3'(fold1[3:2]) + 3'(fold1[1:0]);
		rem3  = (fold2 >= 3'd3) ? 2'(fold2 - 3'd3) : fold2[1:0];
		h_c   = {rem3, time_of_day[LB-1:0]};
	end

	always_comb begin
		if (height_pos < 0) begin
			pcl_c = '0;
		end else if (height_pos > 16'sd4096) begin
			pcl_c = POS_CLAMP_W'(POS_ONE);
		end else begin
			pcl_c = height_pos[POS_CLAMP_W-1:0];
		end
	end

	// lowest segment whose closed interval holds the time wins
	always_comb begin
		seg_c = '0;
		for (int i = KEY_COUNT - 2; i >= 0; i--) begin
			if (i + 1 < KEY_TBL) begin
				if (h_s1 >= (HW'(KEY_HH[i]) << (HOUR_FRAC_BITS - 1)) &&
					h_s1 <= (HW'(KEY_HH[i+1]) << (HOUR_FRAC_BITS - 1))) begin
					seg_c = SEG_W'(i);
				end
			end
		end
		lo_c = HW'(KEY_HH[seg_c]) << (HOUR_FRAC_BITS - 1);
		px_c = ((PXW'(pcl_s1) << COLOR_BITS) + PXW'(POS_ONE / 2)) >> POS_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1    <= h_c;
			pcl_s1  <= pcl_c;
			seg_s2  <= seg_c;
			dist_s2 <= h_s1 - lo_c;
			pos_s2  <= FW'(px_c);
		end
	end

	assign out_valid = vld_s2;
	assign seg       = seg_s2;
	assign hour_off  = dist_s2;
	assign pos       = pos_s2;

endmodule

// ----- rtl/core/kscg_queue.sv -----
// kscg_queue: two-entry queue between the front and back pipelines
// depends on nothing
module kscg_queue #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

// ----- rtl/core/kscg_ease.sv -----
// kscg_ease: two-stage smoothstep x*x*(3*one - 2*x) with rounding
// depends on nothing
module kscg_ease #(
	parameter int COLOR_BITS = 12
) (
	input  logic                clk,
	input  logic                en,
	input  logic [COLOR_BITS:0] x,
	output logic [COLOR_BITS:0] y
);
	localparam int FW = COLOR_BITS + 1;
	localparam int TW = COLOR_BITS + 2;
	localparam int RW = 2*FW + TW;

	logic [2*FW-1:0] sq_s1;
	logic [TW-1:0]   t_s1;
	logic [RW-1:0]   r_s2;
	logic [RW:0]     rnd_c;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= (2*FW)'(x) * (2*FW)'(x);
			t_s1  <= (TW'(3) << COLOR_BITS) - (TW'(x) << 1);
			r_s2  <= RW'(sq_s1) * RW'(t_s1);
		end
	end

	assign rnd_c = ((RW+1)'(r_s2) + ((RW+1)'(1) << (2*COLOR_BITS - 1))) >> (2*COLOR_BITS);
	assign y     = FW'(rnd_c);

endmodule

// ----- rtl/core/kscg_back.sv -----
// kscg_back: segment fraction, easing, key and height blends, output register
// seven pipeline stages; depends on kscg_pkg and kscg_ease
module kscg_back #(
	parameter int COLOR_BITS     = 12,
	parameter int HOUR_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  kscg_pkg::seg_t                    seg,
	input  logic [HOUR_FRAC_BITS+4:0]         hour_off,
	input  logic [COLOR_BITS:0]               pos,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [kscg_pkg::OUT_W-1:0]        red,
	output logic [kscg_pkg::OUT_W-1:0]        green,
	output logic [kscg_pkg::OUT_W-1:0]        blue
);
	import kscg_pkg::*;

	localparam int CB  = COLOR_BITS;
	localparam int FW  = CB + 1;
	localparam int HW  = HOUR_FRAC_BITS + 5;
	localparam int RCW = CB + 15;
	localparam int PW  = HW + RCW;
	localparam int SH  = HOUR_FRAC_BITS + 15;
	localparam int BPW = CB + FW;
	localparam int FPW = 2*FW;
	localparam int XW  = CB + OUT_W;
	localparam logic [FW-1:0] ONE = FW'(1) << CB;
	localparam logic [63:0] NUM = 64'd1 << (CB + 16);

	// rounded 2^(CB+16) / span for each segment, span in half-hours
	localparam logic [RCW-1:0] RECIP [KEY_TBL] = '{
		RCW'((NUM + 64'd5) / 64'd10), RCW'((NUM + 64'd1) / 64'd3),
		RCW'((NUM + 64'd2) / 64'd5),  RCW'((NUM + 64'd3) / 64'd6),
		RCW'((NUM + 64'd5) / 64'd10), RCW'((NUM + 64'd1) / 64'd3),
		RCW'((NUM + 64'd1) / 64'd3),  RCW'((NUM + 64'd4) / 64'd8),
		RCW'(0), RCW'(0), RCW'(0), RCW'(0), RCW'(0), RCW'(0), RCW'(0), RCW'(0)
	};

	function automatic logic [CB-1:0] colour_q(input kcolor_t v);
		logic [CB+16:0] w;
		w = ((CB+17)'(v) << CB) + (CB+17)'(32768);
		return CB'(w >> 16);
	endfunction

	logic                en;
	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [PW-1:0]       prod_s1;
	seg_t                seg_s1, seg_s2;
	logic [FW-1:0]       pos_s1;
	logic [PW:0]         fr_c;
	logic [FW-1:0]       frac_c;
	seg_t                segb_c;
	logic [CB-1:0]       ca_s3 [ROW_LEN];
	logic [CB-1:0]       cb_s3 [ROW_LEN];
	logic [FW-1:0]       f_c, k_c;
	logic [BPW-1:0]      pa_s4 [ROW_LEN];
	logic [BPW-1:0]      pb_s4 [ROW_LEN];
	logic [FW-1:0]       k_s4, k_s5;
	logic [BPW:0]        bs_c [ROW_LEN];
	logic [FW-1:0]       zh_s5 [ROW_LEN];
	logic [FPW-1:0]      ph_s6 [CH_COUNT];
	logic [FPW-1:0]      pz_s6 [CH_COUNT];
	logic [FPW:0]        cs_c [CH_COUNT];
	logic [CB-1:0]       col_s7 [CH_COUNT];
	logic [XW-1:0]       ext_c [CH_COUNT];

	assign en       = !vld_s7 || out_ready;
	assign in_ready = en;

	always_comb begin
		fr_c   = ((PW+1)'(prod_s1) + ((PW+1)'(1) << (SH - 1))) >> SH;
		frac_c = (fr_c > (PW+1)'(ONE)) ? ONE : FW'(fr_c);
		segb_c = seg_s2 + SEG_W'(1);
	end

	kscg_ease #(.COLOR_BITS(CB)) u_ease_t (
		.clk (clk),
		.en  (en),
		.x   (frac_c),
		.y   (f_c)
	);

	kscg_ease #(.COLOR_BITS(CB)) u_ease_p (
		.clk (clk),
		.en  (en),
		.x   (pos_s1),
		.y   (k_c)
	);

	always_comb begin
		for (int j = 0; j < ROW_LEN; j++) begin
			bs_c[j] = ((BPW+1)'(pa_s4[j]) + (BPW+1)'(pb_s4[j]) + (BPW+1)'(ONE >> 1)) >> CB;
		end
		for (int c = 0; c < CH_COUNT; c++) begin
			cs_c[c] = ((FPW+1)'(ph_s6[c]) + (FPW+1)'(pz_s6[c]) + (FPW+1)'(ONE >> 1)) >> CB;
			ext_c[c] = XW'(col_s7[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(hour_off) * PW'(RECIP[seg]);
			seg_s1  <= seg;
			pos_s1  <= pos;
			seg_s2  <= seg_s1;
			for (int j = 0; j < ROW_LEN; j++) begin
				ca_s3[j] <= colour_q(KEY_COLOR[seg_s2][j]);
				cb_s3[j] <= colour_q(KEY_COLOR[segb_c][j]);
				pa_s4[j] <= BPW'(ca_s3[j]) * BPW'(ONE - f_c);
				pb_s4[j] <= BPW'(cb_s3[j]) * BPW'(f_c);
				zh_s5[j] <= FW'(bs_c[j]);
			end
			k_s4 <= k_c;
			k_s5 <= k_s4;
			for (int c = 0; c < CH_COUNT; c++) begin
				// height blend runs from horizon to zenith
				ph_s6[c]  <= FPW'(zh_s5[CH_HOR+c]) * FPW'(ONE - k_s5);
				pz_s6[c]  <= FPW'(zh_s5[CH_ZEN+c]) * FPW'(k_s5);
				col_s7[c] <= (cs_c[c] > (FPW+1)'(ONE - FW'(1))) ? CB'(ONE - FW'(1))
					: CB'(cs_c[c]);
			end
		end
	end

	assign out_valid = vld_s7;
	assign red       = ext_c[0][OUT_W-1:0];
	assign green     = ext_c[1][OUT_W-1:0];
	assign blue      = ext_c[2][OUT_W-1:0];

endmodule

// ----- rtl/core/keyframed_sky_color_gradient_core.sv -----
// keyframed_sky_color_gradient_core: top level of the keyframed sky gradient
// front pipeline, request queue and back pipeline; depends on kscg_pkg,
// kscg_front, kscg_queue, kscg_back
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   request  | in_valid / in_ready  | time_of_day, height_pos
//   result   | out_valid / out_ready| red, green, blue
//
// one request per clock sustained while results are taken at the output
// the rate is set by the fully pipelined back end: 5 multiply stages, 7 in all
// arst_n clears all valid flags and the queue; no clearing pass is needed
// a stalled result holds the back end; the front keeps taking requests until
// its second stage and the two-entry queue fill (up to 11 requests in flight)
module keyframed_sky_color_gradient_core #(
	parameter int KEY_COUNT      = 9,
	parameter int COLOR_BITS     = 12,
	parameter int HOUR_FRAC_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [kscg_pkg::TIME_W-1:0]        time_of_day,
	input  logic signed [kscg_pkg::POS_W-1:0]  height_pos,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [kscg_pkg::OUT_W-1:0]         red,
	output logic [kscg_pkg::OUT_W-1:0]         green,
	output logic [kscg_pkg::OUT_W-1:0]         blue
);
	import kscg_pkg::*;

	localparam int HW = HOUR_FRAC_BITS + 5;
	localparam int FW = COLOR_BITS + 1;
	localparam int QW = SEG_W + HW + FW;

	logic          f_valid, f_ready;
	seg_t          f_seg;
	logic [HW-1:0] f_dist;
	logic [FW-1:0] f_pos;
	logic          q_valid, q_ready;
	logic [QW-1:0] q_data;

	kscg_front #(
		.KEY_COUNT      (KEY_COUNT),
		.COLOR_BITS     (COLOR_BITS),
		.HOUR_FRAC_BITS (HOUR_FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.time_of_day (time_of_day),
		.height_pos  (height_pos),
		.out_valid   (f_valid),
		.out_ready   (f_ready),
		.seg         (f_seg),
		.hour_off    (f_dist),
		.pos         (f_pos)
	);

	kscg_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_seg, f_dist, f_pos}),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	kscg_back #(
		.COLOR_BITS     (COLOR_BITS),
		.HOUR_FRAC_BITS (HOUR_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.seg       (q_data[QW-1 -: SEG_W]),
		.hour_off  (q_data[FW +: HW]),
		.pos       (q_data[FW-1:0]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

// ----- rtl/core/kscg_checker.sv -----
// kscg_checker: port-level checks on the sky gradient core, bound to the top
// depends on kscg_pkg
module kscg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [kscg_pkg::OUT_W-1:0]  red,
	input logic [kscg_pkg::OUT_W-1:0]  green,
	input logic [kscg_pkg::OUT_W-1:0]  blue
);
	import kscg_pkg::*;

	localparam logic [4:0] MAX_INFLIGHT = 5'd11;

	logic       in_acc, out_acc;
	logic [4:0] cnt_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + 5'd1;
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 5'd0)
		else $error("result without an outstanding request");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_INFLIGHT)
		else $error("more requests in flight than the pipeline holds");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 5'd0 |-> in_ready)
		else $error("core not ready while empty");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("stalled result changed");

endmodule

bind keyframed_sky_color_gradient_core kscg_checker u_kscg_checker (.*);
